/* hw/rtl/vfec_pkg.sv */
// shared types and constants for the voxel face exposure check
package vfec_pkg;

    // field widths
    localparam int COORD_W    = 6;
    localparam int DIST_W     = 8;
    localparam int COORD_SPAN = 1 << COORD_W;

    // default map geometry
    localparam int CHUNK_EDGE_DEF = 16;
    localparam int MAP_EDGE_DEF   = 4;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SOLID_THRESHOLD = REG_IDX_W'(0);

    localparam logic signed [DIST_W-1:0] SOLID_THRESHOLD_RST = DIST_W'(3);

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // input transaction
    typedef struct packed {
        logic                      operation;
        logic [COORD_W-1:0]        x_coord;
        logic [COORD_W-1:0]        y_coord;
        logic [COORD_W-1:0]        z_coord;
        logic signed [DIST_W-1:0]  distance;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic is_border;
        logic cell_solid;
    } t_out_item;

endpackage

/* hw/rtl/vfec_ram.sv */
// generic single-port ram with registered read
module vfec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/voxel_face_exposure_check_core.sv */
// voxel occupancy store with six-neighbour exposure queries
//
// Occupancy lives in one single-port memory holding one row of x cells per
// (y, z) pair, SPAN bits wide and SPAN*SPAN rows deep, where SPAN is
// CHUNK_EDGE*MAP_EDGE capped at 64. After reset the block runs a clearing
// pass over all SPAN*SPAN rows (4096 at the default geometry) with in_ready
// low; configuration writes are taken during it. A write transaction steps
// through accept, row read and row write back; a write outside the map ends
// at accept. A query makes five row reads through the single memory port
// (own row, which also holds both x neighbours, then y-1, y+1, z-1, z+1),
// folds the last read in a wait state, then loads the result register; a
// query outside the map goes from accept straight to the result register,
// flagged as border. One transaction is worked on at a time; the result
// register lets the next transaction enter while a result waits to be taken.
module voxel_face_exposure_check_core #(
    parameter int CHUNK_EDGE = vfec_pkg::CHUNK_EDGE_DEF,
    parameter int MAP_EDGE   = vfec_pkg::MAP_EDGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  vfec_pkg::t_in_item               i_in_item,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output vfec_pkg::t_out_item              o_out_item,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vfec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [vfec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [vfec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int CW    = vfec_pkg::COORD_W;
    localparam int MAPC  = CHUNK_EDGE * MAP_EDGE;
    localparam int SPAN  = (MAPC < vfec_pkg::COORD_SPAN) ? MAPC : vfec_pkg::COORD_SPAN;
    localparam int XW    = $clog2(SPAN);
    localparam int DEPTH = SPAN * SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 2 * CW + 1;

    localparam logic [CW:0]    SPAN_C  = (CW+1)'(SPAN);
    localparam logic [XW-1:0]  X_LAST  = XW'(SPAN - 1);
    localparam logic [AW-1:0]  A_LAST  = AW'(DEPTH - 1);

    // query read sequence
    localparam logic [2:0] STEP_ROW = 3'd0;
    localparam logic [2:0] STEP_YM  = 3'd1;
    localparam logic [2:0] STEP_YP  = 3'd2;
    localparam logic [2:0] STEP_ZM  = 3'd3;
    localparam logic [2:0] STEP_ZP  = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_W_RD,
        S_W_WB,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_OUT
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_clr_addr;
    logic [CW-1:0]                   r_x;
    logic [CW-1:0]                   r_y;
    logic [CW-1:0]                   r_z;
    logic                            r_solid_new;
    logic [2:0]                      r_step;
    logic                            r_rd_pend;
    logic [2:0]                      r_chk_step;
    logic                            r_chk_in;
    logic                            r_border;
    logic                            r_self;
    logic                            r_out_valid;
    vfec_pkg::t_out_item             r_out_item;
    logic signed [vfec_pkg::DIST_W-1:0] r_thresh;

    logic                            mem_we;
    logic                            mem_re;
    logic [AW-1:0]                   mem_addr;
    logic [SPAN-1:0]                 mem_wdata;
    logic [SPAN-1:0]                 mem_rdata;

    logic                            in_fire;
    logic                            in_map;
    logic [CW-1:0]                   ny;
    logic [CW-1:0]                   nz;
    logic                            n_inside;
    logic [CW:0]                     y_inc;
    logic [CW:0]                     z_inc;
    logic [XW-1:0]                   ix;
    logic [XW-1:0]                   ixm;
    logic [XW-1:0]                   ixp;
    logic                            open_now;
    logic                            n_border;
    logic                            n_self;
    logic                            cfg_wr;

    // row address of a (y, z) pair
    function automatic logic [AW-1:0] row_addr(input logic [CW-1:0] ry,
                                               input logic [CW-1:0] rz);
        logic [PW-1:0] a;
        a = PW'(rz) * PW'(SPAN) + PW'(ry);
        return a[AW-1:0];
    endfunction

    // occupancy memory
    vfec_ram #(
        .WIDTH (SPAN),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                 && (paddr[vfec_pkg::APB_ADDR_W-1:2] == vfec_pkg::REG_SOLID_THRESHOLD);
    assign prdata = (paddr[vfec_pkg::APB_ADDR_W-1:2] == vfec_pkg::REG_SOLID_THRESHOLD)
                  ? {{(vfec_pkg::APB_DATA_W-vfec_pkg::DIST_W){r_thresh[vfec_pkg::DIST_W-1]}},
                     r_thresh}
                  : '0;

    // input handshake
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_map     = ({1'b0, i_in_item.x_coord} < SPAN_C)
                     && ({1'b0, i_in_item.y_coord} < SPAN_C)
                     && ({1'b0, i_in_item.z_coord} < SPAN_C);

    // neighbour row for the current read step
    assign y_inc = {1'b0, r_y} + (CW+1)'(1);
    assign z_inc = {1'b0, r_z} + (CW+1)'(1);

    always_comb begin
        ny       = r_y;
        nz       = r_z;
        n_inside = 1'b1;
        case (r_step)
            STEP_YM: begin
                ny       = r_y - CW'(1);
                n_inside = (r_y != '0);
            end
            STEP_YP: begin
                ny       = y_inc[CW-1:0];
                n_inside = (y_inc < SPAN_C);
            end
            STEP_ZM: begin
                nz       = r_z - CW'(1);
                n_inside = (r_z != '0);
            end
            STEP_ZP: begin
                nz       = z_inc[CW-1:0];
                n_inside = (z_inc < SPAN_C);
            end
            default: begin
                ny       = r_y;
                nz       = r_z;
                n_inside = 1'b1;
            end
        endcase
    end

    // memory port sharing
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = row_addr(r_y, r_z);
        mem_wdata = mem_rdata;
        mem_wdata[ix] = r_solid_new;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
            end
            S_W_RD: begin
                mem_re = 1'b1;
            end
            S_W_WB: begin
                mem_we = 1'b1;
            end
            S_Q_RD: begin
                mem_re   = 1'b1;
                mem_addr = row_addr(ny, nz);
            end
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    // fold the returned row into the exposure flag
    assign ix  = r_x[XW-1:0];
    assign ixm = ix - XW'(1);
    assign ixp = ix + XW'(1);

    always_comb begin
        if (r_chk_step == STEP_ROW) begin
            open_now = ((ix == '0) || !mem_rdata[ixm])
                    || ((ix == X_LAST) || !mem_rdata[ixp]);
        end else begin
            open_now = !r_chk_in || !mem_rdata[ix];
        end
        n_border = r_border;
        n_self   = r_self;
        if (r_rd_pend) begin
            n_border = r_border || open_now;
            if (r_chk_step == STEP_ROW) begin
                n_self = mem_rdata[ix];
            end
        end
    end

    // sequencer, result register and threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_thresh    <= vfec_pkg::SOLID_THRESHOLD_RST;
        end else begin
            if (cfg_wr) begin
                r_thresh <= pwdata[vfec_pkg::DIST_W-1:0];
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_border  <= n_border;
            r_self    <= n_self;
            r_rd_pend <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == A_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_x         <= i_in_item.x_coord;
                        r_y         <= i_in_item.y_coord;
                        r_z         <= i_in_item.z_coord;
                        r_solid_new <= (i_in_item.distance > r_thresh);
                        r_step      <= STEP_ROW;
                        if (i_in_item.operation == vfec_pkg::OP_WRITE) begin
                            if (in_map) begin
                                r_state <= S_W_RD;
                            end
                        end else if (in_map) begin
                            r_border <= 1'b0;
                            r_self   <= 1'b0;
                            r_state  <= S_Q_RD;
                        end else begin
                            r_border <= 1'b1;
                            r_self   <= 1'b0;
                            r_state  <= S_Q_OUT;
                        end
                    end
                end
                S_W_RD: begin
                    r_state <= S_W_WB;
                end
                S_W_WB: begin
                    r_state <= S_IDLE;
                end
                S_Q_RD: begin
                    r_rd_pend  <= 1'b1;
                    r_chk_step <= r_step;
                    r_chk_in   <= n_inside;
                    r_step     <= r_step + 3'd1;
                    if (r_step == STEP_ZP) begin
                        r_state <= S_Q_WAIT;
                    end
                end
                S_Q_WAIT: begin
                    r_state <= S_Q_OUT;
                end
                S_Q_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid           <= 1'b1;
                        r_out_item.is_border  <= r_border;
                        r_out_item.cell_solid <= r_self;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // the single memory port never reads and writes in one cycle
    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("occupancy read and write in the same cycle");

    // no result appears before the clearing pass has ended
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");

    // a write transaction never creates a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_WB && !r_out_valid) |=> !r_out_valid)
        else $error("write produced a result");

    // the query read sequence runs without gaps
    a_query_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_RD && r_step != STEP_ZP) |=> (r_state == S_Q_RD && r_rd_pend))
        else $error("query read sequence broken");

endmodule
